### hw/rtl/cosine_nearest_face_match_defines.svh
// ----------------------------------------------------------------------------
// Cosine nearest face match: shared assertion macros
// Concurrent checks clocked on clock and quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef COSINE_NEAREST_FACE_MATCH_DEFINES_SVH
`define COSINE_NEAREST_FACE_MATCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CNFM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CNFM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/cnfm_pkg.sv
// ----------------------------------------------------------------------------
// Cosine nearest face match package
// Sizes, payload structs, status and register codes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cnfm_pkg;

   // Table geometry.
   localparam int ENTRIES = 64;
   localparam int DIM     = 128;

   // Field widths.
   localparam int ELEM_W = 16;
   localparam int ID_W   = 32;
   localparam int TIME_W = 32;
   localparam int EXP_W  = 24;
   localparam int SIM_W  = 16;
   localparam int DATA_W = 32;

   // Index and counter widths derived from the geometry.
   localparam int ENT_W = $clog2((ENTRIES > 1) ? ENTRIES : 2);
   localparam int IDX_W = $clog2(DIM);
   localparam int CNT_W = $clog2(DIM + 1);
   localparam int FA_W  = $clog2(ENTRIES * DIM);

   // Arithmetic widths: sum of squares, signed dot product, norm and divisor.
   localparam int PROD_W = 2 * ELEM_W;
   localparam int SQ_W   = PROD_W - 1 + IDX_W;
   localparam int ACC_W  = PROD_W + IDX_W;
   localparam int NORM_W = SQ_W / 2 + 1;
   localparam int RT_W   = SQ_W + 2;
   localparam int DEN_W  = 2 * NORM_W;
   localparam int QT_W   = 16;
   localparam int QK_W   = $clog2(QT_W);
   localparam int FRAC_W = 15;
   localparam int NUM_W  = ACC_W + FRAC_W;
   localparam int CMP_W  = ((NUM_W > DEN_W + QT_W) ? NUM_W : DEN_W + QT_W) + 1;

   // Result status codes.
   localparam logic [1:0] STATUS_MATCH   = 2'd0;
   localparam logic [1:0] STATUS_ENROL   = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   // Request actions.
   localparam logic ACTION_ELEMENT = 1'b0;
   localparam logic ACTION_EXPIRE  = 1'b1;

   // Register indexes.
   localparam logic [1:0] CSR_MATCH  = 2'd0;
   localparam logic [1:0] CSR_ENROL  = 2'd1;
   localparam logic [1:0] CSR_EXPIRE = 2'd2;

   // Register reset values.
   localparam logic signed [SIM_W-1:0] MATCH_RESET  = 16'sd19661;
   localparam logic signed [SIM_W-1:0] ENROL_RESET  = 16'sd16384;
   localparam logic        [EXP_W-1:0] EXPIRE_RESET = 24'd1800;

   // Extreme similarity values.
   localparam logic signed [SIM_W-1:0] SIM_MIN = 16'sh8000;
   localparam logic signed [SIM_W-1:0] SIM_MAX = 16'sh7FFF;

   typedef struct packed {
      logic                     action;
      logic signed [ELEM_W-1:0] element;
      logic                     last_element;
      logic [TIME_W-1:0]        now_seconds;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [ID_W-1:0]         face_id;
      logic signed [SIM_W-1:0] best_similarity;
   } rsp_type;

   // Command passed from the front to the back through the queue.
   typedef struct packed {
      logic              expire;
      logic [TIME_W-1:0] now_seconds;
   } cmd_type;

   // Control from the back to the front.
   typedef struct packed {
      logic busy;
      logic pop;
      logic clear;
   } back_ctl_type;

   // Query buffer read port driven by the back.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
   } qrd_type;

   // Configuration register set.
   typedef struct packed {
      logic signed [SIM_W-1:0] match_threshold;
      logic signed [SIM_W-1:0] enrol_threshold;
      logic [EXP_W-1:0]        expire_seconds;
   } cfg_type;

   // Stored entry information.
   typedef struct packed {
      logic [NORM_W-1:0] norm;
      logic [ID_W-1:0]   id;
   } info_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_NORM_RUN,
      ST_NORM_DRAIN,
      ST_SQRT,
      ST_ENT_RD,
      ST_ENT_CHK,
      ST_DOT_RUN,
      ST_DOT_DRAIN,
      ST_DIV_PREP,
      ST_DIV_OVF,
      ST_DIV_STEP,
      ST_SCORE,
      ST_DECIDE,
      ST_COPY_RUN,
      ST_COPY_DRAIN,
      ST_REPORT,
      ST_EXP_RD,
      ST_EXP_CHK
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/cnfm_front.sv
// ----------------------------------------------------------------------------
// Cosine nearest face match: front end
// Takes requests, gathers query elements in the buffer and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cnfm_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire cnfm_pkg::req_type             req_data,
   input  wire cnfm_pkg::back_ctl_type        ctl,
   input  wire cnfm_pkg::qrd_type             qrd,
   output logic signed [cnfm_pkg::ELEM_W-1:0] q_rd_data,
   output logic                               cmd_valid,
   output cnfm_pkg::cmd_type                  cmd
);

   logic signed [cnfm_pkg::ELEM_W-1:0] qbuf [cnfm_pkg::DIM];
   logic signed [cnfm_pkg::ELEM_W-1:0] q_mem_rd_ff;
   logic                               q_in_range_ff;
   logic [cnfm_pkg::CNT_W-1:0]         count_ff, count_in;
   cnfm_pkg::cmd_type                  fifo_mem [2];
   logic                               wr_ptr_ff, wr_ptr_in;
   logic                               rd_ptr_ff, rd_ptr_in;
   logic [1:0]                         fifo_cnt_ff, fifo_cnt_in;
   logic                               accept;
   logic                               push;
   logic                               store;
   cnfm_pkg::cmd_type                  push_cmd;

   // Requests wait while the back works or a command is still queued.
   always_comb begin
      req_stall = ctl.busy || (fifo_cnt_ff != 2'd0);
      accept    = req_valid && !req_stall;
      push      = accept && ((req_data.action == cnfm_pkg::ACTION_EXPIRE) ||
                             req_data.last_element);
      store     = accept && (req_data.action == cnfm_pkg::ACTION_ELEMENT) &&
                  (count_ff < cnfm_pkg::CNT_W'(cnfm_pkg::DIM));
      push_cmd.expire      = (req_data.action == cnfm_pkg::ACTION_EXPIRE);
      push_cmd.now_seconds = req_data.now_seconds;
   end

   // Element count and queue pointers.
   always_comb begin
      count_in    = count_ff;
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      fifo_cnt_in = fifo_cnt_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (store) begin
         count_in = count_ff + 1'b1;
      end
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (ctl.pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !ctl.pop) begin
         fifo_cnt_in = fifo_cnt_ff + 2'd1;
      end else if (!push && ctl.pop) begin
         fifo_cnt_in = fifo_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         fifo_cnt_ff <= 2'd0;
      end else begin
         count_ff    <= count_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   // Command queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_cmd;
      end
   end

   assign cmd_valid = (fifo_cnt_ff != 2'd0);
   assign cmd       = fifo_mem[rd_ptr_ff];

   // Query buffer; places not yet written this vector read as zero.
   always_ff @(posedge clock) begin
      if (store) begin
         qbuf[count_ff[cnfm_pkg::IDX_W-1:0]] <= req_data.element;
      end
   end

   always_ff @(posedge clock) begin
      if (qrd.en) begin
         q_mem_rd_ff   <= qbuf[qrd.idx];
         q_in_range_ff <= ({1'b0, qrd.idx} < count_ff);
      end
   end

   assign q_rd_data = q_in_range_ff ? q_mem_rd_ff : '0;

endmodule

`default_nettype wire

### hw/rtl/cnfm_back.sv
// ----------------------------------------------------------------------------
// Cosine nearest face match: back end
// Sequencer (one multiplier, square root unit, divider) that scores each stored
// entry of non-zero norm, decides the outcome, enrols and runs expiry sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cosine_nearest_face_match_defines.svh"

module cnfm_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire cnfm_pkg::cfg_type                  cfg,
   input  wire logic                               cmd_valid,
   input  wire cnfm_pkg::cmd_type                  cmd,
   input  wire logic signed [cnfm_pkg::ELEM_W-1:0] q_rd_data,
   output cnfm_pkg::back_ctl_type                  ctl,
   output cnfm_pkg::qrd_type                       qrd,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output cnfm_pkg::rsp_type                       rsp_data
);

   // Stores.
   logic signed [cnfm_pkg::ELEM_W-1:0] feat_mem [cnfm_pkg::ENTRIES * cnfm_pkg::DIM];
   cnfm_pkg::info_type                 info_mem [cnfm_pkg::ENTRIES];
   logic [cnfm_pkg::TIME_W-1:0]        time_mem [cnfm_pkg::ENTRIES];
   logic signed [cnfm_pkg::ELEM_W-1:0] feat_rd_ff;
   cnfm_pkg::info_type                 info_rd_ff;
   logic [cnfm_pkg::TIME_W-1:0]        time_rd_ff;
   logic [cnfm_pkg::ENTRIES-1:0]       valid_ff, valid_in;

   // Sequencer and data path registers.
   cnfm_pkg::state_type                state_ff, state_in;
   logic [cnfm_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic                               s1_ff, s1_in;
   logic [cnfm_pkg::IDX_W-1:0]         s1_idx_ff;
   logic                               s2_ff, s2_in;
   logic signed [cnfm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [cnfm_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [cnfm_pkg::NORM_W-1:0]        nq_ff, nq_in;
   logic [cnfm_pkg::RT_W-1:0]          sq_n_ff, sq_n_in;
   logic [cnfm_pkg::RT_W-1:0]          sq_res_ff, sq_res_in;
   logic [cnfm_pkg::RT_W-1:0]          sq_bit_ff, sq_bit_in;
   logic [cnfm_pkg::ENT_W-1:0]         ent_ff, ent_in;
   logic [cnfm_pkg::FA_W-1:0]          base_ff, base_in;
   logic [cnfm_pkg::DEN_W-1:0]         den_ff, den_in;
   logic                               neg_ff, neg_in;
   logic [cnfm_pkg::ACC_W-1:0]         mag_ff, mag_in;
   logic [cnfm_pkg::CMP_W-1:0]         rem_ff, rem_in;
   logic [cnfm_pkg::CMP_W-1:0]         dsh_ff, dsh_in;
   logic [cnfm_pkg::QT_W-1:0]          quo_ff, quo_in;
   logic                               ovf_ff, ovf_in;
   logic [cnfm_pkg::QK_W-1:0]          dk_ff, dk_in;
   logic                               found_ff, found_in;
   logic signed [cnfm_pkg::SIM_W-1:0]  best_ff, best_in;
   logic [cnfm_pkg::ENT_W-1:0]         best_slot_ff, best_slot_in;
   logic [cnfm_pkg::ID_W-1:0]          best_id_ff, best_id_in;
   logic                               free_found_ff, free_found_in;
   logic [cnfm_pkg::ENT_W-1:0]         free_slot_ff, free_slot_in;
   logic [cnfm_pkg::FA_W-1:0]          free_base_ff, free_base_in;
   logic [cnfm_pkg::ID_W-1:0]          next_id_ff, next_id_in;
   logic [cnfm_pkg::TIME_W-1:0]        now_ff, now_in;
   logic [1:0]                         res_status_ff, res_status_in;
   logic [cnfm_pkg::ID_W-1:0]          res_id_ff, res_id_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   cnfm_pkg::rsp_type                  rsp_ff, rsp_in;

   // Memory control.
   logic                               feat_rd_en, feat_we;
   logic [cnfm_pkg::FA_W-1:0]          feat_rd_addr, feat_wr_addr;
   logic                               info_rd_en, info_we;
   logic                               time_rd_en, time_we;
   logic [cnfm_pkg::ENT_W-1:0]         time_wr_addr;

   // Helpers.
   logic                               run_state, copy_mode, norm_mode;
   logic [cnfm_pkg::RT_W-1:0]          sq_try;
   logic [cnfm_pkg::CMP_W-1:0]         num_ext, den_top;
   logic signed [cnfm_pkg::SIM_W-1:0]  score;
   logic signed [cnfm_pkg::TIME_W+1:0] age;
   logic                               candidate;
   logic                               last_ent;

   always_comb begin
      run_state = (state_ff == cnfm_pkg::ST_NORM_RUN) ||
                  (state_ff == cnfm_pkg::ST_DOT_RUN) ||
                  (state_ff == cnfm_pkg::ST_COPY_RUN);
      copy_mode = (state_ff == cnfm_pkg::ST_COPY_RUN) ||
                  (state_ff == cnfm_pkg::ST_COPY_DRAIN);
      norm_mode = (state_ff == cnfm_pkg::ST_NORM_RUN) ||
                  (state_ff == cnfm_pkg::ST_NORM_DRAIN);
      last_ent  = (ent_ff == cnfm_pkg::ENT_W'(cnfm_pkg::ENTRIES - 1));
      sq_try    = sq_res_ff + sq_bit_ff;
      num_ext   = cnfm_pkg::CMP_W'({mag_ff, {cnfm_pkg::FRAC_W{1'b0}}});
      den_top   = cnfm_pkg::CMP_W'(den_ff) << cnfm_pkg::QT_W;
      candidate = valid_ff[ent_ff] && (nq_ff != '0) && (info_rd_ff.norm != '0);
      age       = $signed({2'b00, now_ff}) - $signed({2'b00, time_rd_ff});
      // Saturate the quotient to a Q1.15 similarity with the dot product sign.
      if (neg_ff) begin
         score = (ovf_ff || quo_ff[cnfm_pkg::QT_W-1]) ? cnfm_pkg::SIM_MIN :
                 cnfm_pkg::SIM_W'(-$signed({1'b0, quo_ff}));
      end else begin
         score = (ovf_ff || quo_ff[cnfm_pkg::QT_W-1]) ? cnfm_pkg::SIM_MAX :
                 $signed(quo_ff);
      end
   end

   // Next state and data path.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      s1_in         = run_state;
      s2_in         = s1_ff && !copy_mode;
      prod_in       = q_rd_data * (norm_mode ? q_rd_data : feat_rd_ff);
      acc_in        = acc_ff;
      nq_in         = nq_ff;
      sq_n_in       = sq_n_ff;
      sq_res_in     = sq_res_ff;
      sq_bit_in     = sq_bit_ff;
      ent_in        = ent_ff;
      base_in       = base_ff;
      den_in        = den_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      rem_in        = rem_ff;
      dsh_in        = dsh_ff;
      quo_in        = quo_ff;
      ovf_in        = ovf_ff;
      dk_in         = dk_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_slot_in  = best_slot_ff;
      best_id_in    = best_id_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      free_base_in  = free_base_ff;
      next_id_in    = next_id_ff;
      now_in        = now_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      valid_in      = valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ctl.busy      = (state_ff != cnfm_pkg::ST_IDLE);
      ctl.pop       = 1'b0;
      ctl.clear     = 1'b0;
      qrd.en        = run_state;
      qrd.idx       = idx_ff;
      feat_rd_en    = (state_ff == cnfm_pkg::ST_DOT_RUN);
      feat_rd_addr  = base_ff + cnfm_pkg::FA_W'(idx_ff);
      feat_we       = s1_ff && copy_mode;
      feat_wr_addr  = free_base_ff + cnfm_pkg::FA_W'(s1_idx_ff);
      info_rd_en    = (state_ff == cnfm_pkg::ST_ENT_RD);
      info_we       = 1'b0;
      time_rd_en    = (state_ff == cnfm_pkg::ST_EXP_RD);
      time_we       = 1'b0;
      time_wr_addr  = free_slot_ff;

      // Accumulate products coming out of the multiplier stage.
      if (s2_ff) begin
         acc_in = acc_ff + cnfm_pkg::ACC_W'(prod_ff);
      end

      case (state_ff)
         cnfm_pkg::ST_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               ctl.pop = 1'b1;
               now_in  = cmd.now_seconds;
               ent_in  = '0;
               idx_in  = '0;
               acc_in  = '0;
               if (cmd.expire) begin
                  state_in = cnfm_pkg::ST_EXP_RD;
               end else begin
                  state_in = cnfm_pkg::ST_NORM_RUN;
               end
            end
         end
         // Sum of squares of the query.
         cnfm_pkg::ST_NORM_RUN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == cnfm_pkg::IDX_W'(cnfm_pkg::DIM - 1)) begin
               state_in = cnfm_pkg::ST_NORM_DRAIN;
            end
         end
         cnfm_pkg::ST_NORM_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               sq_n_in   = cnfm_pkg::RT_W'(acc_ff);
               sq_res_in = '0;
               sq_bit_in = cnfm_pkg::RT_W'(1) << (2 * (cnfm_pkg::NORM_W - 1));
               state_in  = cnfm_pkg::ST_SQRT;
            end
         end
         // Integer square root, one result bit a cycle.
         cnfm_pkg::ST_SQRT: begin
            if (sq_n_ff >= sq_try) begin
               sq_n_in   = sq_n_ff - sq_try;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               nq_in         = cnfm_pkg::NORM_W'(sq_res_in);
               ent_in        = '0;
               base_in       = '0;
               found_in      = 1'b0;
               best_in       = cnfm_pkg::SIM_MIN;
               free_found_in = 1'b0;
               state_in      = cnfm_pkg::ST_ENT_RD;
            end
         end
         cnfm_pkg::ST_ENT_RD: begin
            state_in = cnfm_pkg::ST_ENT_CHK;
         end
         // Note the lowest free slot and skip entries that cannot be compared.
         cnfm_pkg::ST_ENT_CHK: begin
            if (!valid_ff[ent_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_slot_in  = ent_ff;
               free_base_in  = base_ff;
            end
            if (candidate) begin
               idx_in   = '0;
               acc_in   = '0;
               state_in = cnfm_pkg::ST_DOT_RUN;
            end else if (last_ent) begin
               state_in = cnfm_pkg::ST_DECIDE;
            end else begin
               ent_in   = ent_ff + 1'b1;
               base_in  = base_ff + cnfm_pkg::FA_W'(cnfm_pkg::DIM);
               state_in = cnfm_pkg::ST_ENT_RD;
            end
         end
         cnfm_pkg::ST_DOT_RUN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == cnfm_pkg::IDX_W'(cnfm_pkg::DIM - 1)) begin
               state_in = cnfm_pkg::ST_DOT_DRAIN;
            end
         end
         cnfm_pkg::ST_DOT_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = cnfm_pkg::ST_DIV_PREP;
            end
         end
         // Product of the two norms and magnitude of the dot product.
         cnfm_pkg::ST_DIV_PREP: begin
            den_in   = nq_ff * info_rd_ff.norm;
            neg_in   = acc_ff[cnfm_pkg::ACC_W-1];
            mag_in   = acc_ff[cnfm_pkg::ACC_W-1] ? cnfm_pkg::ACC_W'(-acc_ff) :
                       cnfm_pkg::ACC_W'(acc_ff);
            state_in = cnfm_pkg::ST_DIV_OVF;
         end
         cnfm_pkg::ST_DIV_OVF: begin
            ovf_in   = (num_ext >= den_top);
            rem_in   = num_ext;
            dsh_in   = cnfm_pkg::CMP_W'(den_ff) << (cnfm_pkg::QT_W - 1);
            quo_in   = '0;
            dk_in    = '0;
            state_in = cnfm_pkg::ST_DIV_STEP;
         end
         // Restoring division, one quotient bit a cycle.
         cnfm_pkg::ST_DIV_STEP: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               quo_in = {quo_ff[cnfm_pkg::QT_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[cnfm_pkg::QT_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            dk_in  = dk_ff + 1'b1;
            if (dk_ff == cnfm_pkg::QK_W'(cnfm_pkg::QT_W - 1)) begin
               state_in = cnfm_pkg::ST_SCORE;
            end
         end
         // Keep the best score; equal scores go to the lower id.
         cnfm_pkg::ST_SCORE: begin
            if (!found_ff || (score > best_ff) ||
                ((score == best_ff) && (info_rd_ff.id < best_id_ff))) begin
               found_in     = 1'b1;
               best_in      = score;
               best_slot_in = ent_ff;
               best_id_in   = info_rd_ff.id;
            end
            if (last_ent) begin
               state_in = cnfm_pkg::ST_DECIDE;
            end else begin
               ent_in   = ent_ff + 1'b1;
               base_in  = base_ff + cnfm_pkg::FA_W'(cnfm_pkg::DIM);
               state_in = cnfm_pkg::ST_ENT_RD;
            end
         end
         // Match, enrol, report full or report unknown.
         cnfm_pkg::ST_DECIDE: begin
            res_id_in = '0;
            state_in  = cnfm_pkg::ST_REPORT;
            if (found_ff && (best_ff >= cfg.match_threshold)) begin
               time_we       = 1'b1;
               time_wr_addr  = best_slot_ff;
               res_status_in = cnfm_pkg::STATUS_MATCH;
               res_id_in     = best_id_ff;
            end else if (!found_ff || (best_ff < cfg.enrol_threshold)) begin
               if (free_found_ff) begin
                  info_we                 = 1'b1;
                  time_we                 = 1'b1;
                  valid_in[free_slot_ff]  = 1'b1;
                  res_status_in           = cnfm_pkg::STATUS_ENROL;
                  res_id_in               = next_id_ff;
                  next_id_in              = next_id_ff + 1'b1;
                  idx_in                  = '0;
                  state_in                = cnfm_pkg::ST_COPY_RUN;
               end else begin
                  res_status_in = cnfm_pkg::STATUS_FULL;
               end
            end else begin
               res_status_in = cnfm_pkg::STATUS_UNKNOWN;
            end
         end
         // Copy the query into the chosen slot.
         cnfm_pkg::ST_COPY_RUN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == cnfm_pkg::IDX_W'(cnfm_pkg::DIM - 1)) begin
               state_in = cnfm_pkg::ST_COPY_DRAIN;
            end
         end
         cnfm_pkg::ST_COPY_DRAIN: begin
            if (!s1_ff) begin
               state_in = cnfm_pkg::ST_REPORT;
            end
         end
         cnfm_pkg::ST_REPORT: begin
            rsp_in.status          = res_status_ff;
            rsp_in.face_id         = res_id_ff;
            rsp_in.best_similarity = best_ff;
            rsp_valid_in           = 1'b1;
            ctl.clear              = 1'b1;
            state_in               = cnfm_pkg::ST_IDLE;
         end
         // Expiry sweep, one entry at a time through a read state and a check state.
         cnfm_pkg::ST_EXP_RD: begin
            state_in = cnfm_pkg::ST_EXP_CHK;
         end
         cnfm_pkg::ST_EXP_CHK: begin
            if (valid_ff[ent_ff] &&
                (age > $signed({10'b0, cfg.expire_seconds}))) begin
               valid_in[ent_ff] = 1'b0;
            end
            if (last_ent) begin
               state_in = cnfm_pkg::ST_IDLE;
            end else begin
               ent_in   = ent_ff + 1'b1;
               state_in = cnfm_pkg::ST_EXP_RD;
            end
         end
         default: begin
            state_in = cnfm_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cnfm_pkg::ST_IDLE;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         valid_ff     <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         valid_ff     <= valid_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      s1_idx_ff     <= idx_ff;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      nq_ff         <= nq_in;
      sq_n_ff       <= sq_n_in;
      sq_res_ff     <= sq_res_in;
      sq_bit_ff     <= sq_bit_in;
      ent_ff        <= ent_in;
      base_ff       <= base_in;
      den_ff        <= den_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      rem_ff        <= rem_in;
      dsh_ff        <= dsh_in;
      quo_ff        <= quo_in;
      ovf_ff        <= ovf_in;
      dk_ff         <= dk_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_slot_ff  <= best_slot_in;
      best_id_ff    <= best_id_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      free_base_ff  <= free_base_in;
      now_ff        <= now_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_ff        <= rsp_in;
   end

   // Feature store.
   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_mem[feat_wr_addr] <= q_rd_data;
      end
      if (feat_rd_en) begin
         feat_rd_ff <= feat_mem[feat_rd_addr];
      end
   end

   // Entry norm and id.
   always_ff @(posedge clock) begin
      if (info_we) begin
         info_mem[free_slot_ff] <= '{norm: nq_ff, id: next_id_ff};
      end
      if (info_rd_en) begin
         info_rd_ff <= info_mem[ent_ff];
      end
   end

   // Entry time stamps.
   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[time_wr_addr] <= now_ff;
      end
      if (time_rd_en) begin
         time_rd_ff <= time_mem[ent_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A new command is only taken by an idle sequencer with the result slot free.
   `CNFM_ASSERT_SAME(a_pop_idle, ctl.pop, (state_ff == cnfm_pkg::ST_IDLE) && !rsp_valid_ff, "pop while not idle")
   // The result register is empty whenever a result is produced.
   `CNFM_ASSERT_SAME(a_report_free, state_ff == cnfm_pkg::ST_REPORT, !rsp_valid_ff, "result overwritten")
   // A produced result is visible in the next cycle.
   `CNFM_ASSERT_NEXT(a_report_shown, state_ff == cnfm_pkg::ST_REPORT, rsp_valid_ff, "result lost")
   // The multiply pipeline is empty before the divider takes the dot product.
   `CNFM_ASSERT_SAME(a_drained, state_ff == cnfm_pkg::ST_DIV_PREP, !s1_ff && !s2_ff, "dot not drained")

endmodule

`default_nettype wire

### hw/rtl/cosine_nearest_face_match.sv
// Search: the last query element starts a search that computes the query norm, visits
// every table entry, scores each valid entry with a non-zero norm and copies the query
// into a free slot when it is enrolled, before the result appears.
// The single multiply-accumulate unit and the feature store read port set the rate;
// an expiry sweep visits every table entry. Reset is synchronous: it empties the
// table, the queue and the query buffer and loads the register reset values.
// ----------------------------------------------------------------------------
// Cosine nearest face match: top level
// Register bank and the front and back ends of the matcher.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_nearest_face_match (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire cnfm_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output cnfm_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [cnfm_pkg::DATA_W-1:0]   csr_wdata
);

   cnfm_pkg::cfg_type                  cfg_ff, cfg_in;
   cnfm_pkg::back_ctl_type             ctl;
   cnfm_pkg::qrd_type                  qrd;
   cnfm_pkg::cmd_type                  cmd;
   logic                               cmd_valid;
   logic signed [cnfm_pkg::ELEM_W-1:0] q_rd_data;

   assign csr_ready = 1'b1;

   // Register writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            cnfm_pkg::CSR_MATCH: begin
               cfg_in.match_threshold = csr_wdata[cnfm_pkg::SIM_W-1:0];
            end
            cnfm_pkg::CSR_ENROL: begin
               cfg_in.enrol_threshold = csr_wdata[cnfm_pkg::SIM_W-1:0];
            end
            cnfm_pkg::CSR_EXPIRE: begin
               cfg_in.expire_seconds = csr_wdata[cnfm_pkg::EXP_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_threshold <= cnfm_pkg::MATCH_RESET;
         cfg_ff.enrol_threshold <= cnfm_pkg::ENROL_RESET;
         cfg_ff.expire_seconds  <= cnfm_pkg::EXPIRE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cnfm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .ctl       (ctl),
      .qrd       (qrd),
      .q_rd_data (q_rd_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   cnfm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .q_rd_data (q_rd_data),
      .ctl       (ctl),
      .qrd       (qrd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// Cosine nearest face match testbench
// Drives query elements and expiry sweeps through a directed table and then
// random phases under several register settings. Every result is checked against
// a typed expectation or a behavioural predictor of the match table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   cnfm_pkg::req_type           req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   cnfm_pkg::rsp_type           rsp_data;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [1:0]                  csr_index = cnfm_pkg::CSR_MATCH;
   logic [cnfm_pkg::DATA_W-1:0] csr_wdata = '0;

   cosine_nearest_face_match DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Predictor state: a copy of the face table and the registers.
   shortint           pend_query [cnfm_pkg::DIM];
   int unsigned       pend_count;
   shortint           face_vec [cnfm_pkg::ENTRIES][cnfm_pkg::DIM];
   bit                face_live [cnfm_pkg::ENTRIES];
   int unsigned       face_ident [cnfm_pkg::ENTRIES];
   int unsigned       face_stamp [cnfm_pkg::ENTRIES];
   longint unsigned   face_norm [cnfm_pkg::ENTRIES];
   int unsigned       id_counter;
   int                thr_match, thr_enrol;
   int unsigned       max_age;

   cnfm_pkg::rsp_type pending_rsp [$];
   int                errors = 0;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic int cosine_score(int slot, longint unsigned nq);
      longint dot;
      longint unsigned mag, quo;
      dot = 0;
      for (int i = 0; i < cnfm_pkg::DIM; i++)
         dot += longint'(pend_query[i]) * longint'(face_vec[slot][i]);
      mag = (dot < 0) ? longint'(-dot) : longint'(dot);
      quo = (mag << 15) / (nq * face_norm[slot]);
      if (dot < 0) return (quo >= 32768) ? -32768 : -int'(quo);
      return (quo > 32767) ? 32767 : int'(quo);
   endfunction

   // Applies one accepted request to the table copy; has_rsp flags a result.
   task automatic predict_match(input cnfm_pkg::req_type r, output bit has_rsp,
                                output cnfm_pkg::rsp_type o);
      longint unsigned sq, nq;
      bit found;
      int best_slot, best, s, slot;
      has_rsp = 0;
      o = '0;
      if (r.action == cnfm_pkg::ACTION_EXPIRE) begin
         for (int e = 0; e < cnfm_pkg::ENTRIES; e++)
            if (face_live[e] && (longint'(r.now_seconds) - longint'(face_stamp[e]) >
                                 longint'(max_age)))
               face_live[e] = 0;
         return;
      end
      if (pend_count < cnfm_pkg::DIM) begin
         pend_query[pend_count] = r.element;
         pend_count++;
      end
      if (!r.last_element) return;
      sq = 0;
      for (int i = 0; i < cnfm_pkg::DIM; i++)
         sq += longint'(pend_query[i]) * longint'(pend_query[i]);
      nq = int_sqrt(sq);
      found = 0;
      best_slot = 0;
      best = -32768;
      for (int e = 0; e < cnfm_pkg::ENTRIES; e++) begin
         if (!face_live[e] || nq == 0 || face_norm[e] == 0) continue;
         s = cosine_score(e, nq);
         if (!found || s > best || (s == best && face_ident[e] < face_ident[best_slot])) begin
            found = 1;
            best = s;
            best_slot = e;
         end
      end
      if (found && best >= thr_match) begin
         face_stamp[best_slot] = r.now_seconds;
         o.status = cnfm_pkg::STATUS_MATCH;
         o.face_id = face_ident[best_slot];
      end else if (!found || best < thr_enrol) begin
         slot = -1;
         for (int e = 0; e < cnfm_pkg::ENTRIES; e++)
            if (!face_live[e]) begin
               slot = e;
               break;
            end
         if (slot < 0) begin
            o.status = cnfm_pkg::STATUS_FULL;
         end else begin
            for (int i = 0; i < cnfm_pkg::DIM; i++) face_vec[slot][i] = pend_query[i];
            face_norm[slot] = nq;
            face_stamp[slot] = r.now_seconds;
            face_ident[slot] = id_counter;
            face_live[slot] = 1;
            o.status = cnfm_pkg::STATUS_ENROL;
            o.face_id = id_counter;
            id_counter++;
         end
      end else begin
         o.status = cnfm_pkg::STATUS_UNKNOWN;
      end
      o.best_similarity = best[15:0];
      for (int i = 0; i < cnfm_pkg::DIM; i++) pend_query[i] = 0;
      pend_count = 0;
      has_rsp = 1;
   endtask

   // Sends one request; the expected result is the typed one when given.
   task automatic send_request(input cnfm_pkg::req_type r, input bit typed,
                               input cnfm_pkg::rsp_type t);
      bit has;
      cnfm_pkg::rsp_type o;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict_match(r, has, o);
      if (has) pending_rsp = {pending_rsp, (typed ? t : o)};
   endtask

   task automatic idle_sender(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Waits for every result, then for a possible sweep to finish.
   task automatic drain_results();
      idle_sender(0);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * cnfm_pkg::ENTRIES + 40) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [cnfm_pkg::DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         cnfm_pkg::CSR_MATCH:  thr_match = int'(signed'(val[15:0]));
         cnfm_pkg::CSR_ENROL:  thr_enrol = int'(signed'(val[15:0]));
         cnfm_pkg::CSR_EXPIRE: max_age = val[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic cnfm_pkg::req_type mk_req(logic act, int elem, logic last,
                                                int unsigned now);
      cnfm_pkg::req_type r;
      r.action = act;
      r.element = elem[15:0];
      r.last_element = last;
      r.now_seconds = now;
      return r;
   endfunction

   // Receiver stall pattern: runs of free flow or of random stalling at two densities.
   int stall_mode = 0, stall_left = 0;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(1, 200);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   // Result checker.
   always @(posedge clock) begin
      cnfm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result %p", $realtime, rsp_data);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                        rsp_data.status);
               errors++;
            end
            if (rsp_data.face_id !== want.face_id) begin
               $display("%0t: face_id expected %0d actual %0d", $realtime, want.face_id,
                        rsp_data.face_id);
               errors++;
            end
            if (rsp_data.best_similarity !== want.best_similarity) begin
               $display("%0t: best_similarity expected %0d actual %0d", $realtime,
                        want.best_similarity, rsp_data.best_similarity);
               errors++;
            end
         end
      end
   end

   initial begin
      #2_000_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   typedef struct {
      cnfm_pkg::req_type r;
      bit                typed;
      cnfm_pkg::rsp_type e;
   } dir_row_type;

   function automatic dir_row_type row(cnfm_pkg::req_type r, bit typed, logic [1:0] st,
                                       int unsigned id, int sim);
      dir_row_type d;
      d.r = r;
      d.typed = typed;
      d.e.status = st;
      d.e.face_id = id;
      d.e.best_similarity = sim[15:0];
      return d;
   endfunction

   initial begin
      dir_row_type dir [$];
      shortint proto [8][8];
      int unsigned tnow;
      int burst, len, p, elem, n_items, quota, rnd;
      int phase_cfg [5][3];
      cnfm_pkg::rsp_type none;

      none = '0;
      // Predictor reset state.
      for (int i = 0; i < cnfm_pkg::DIM; i++) pend_query[i] = 0;
      for (int e = 0; e < cnfm_pkg::ENTRIES; e++) face_live[e] = 0;
      pend_count = 0;
      id_counter = 0;
      thr_match = 19661;
      thr_enrol = 16384;
      max_age = 1800;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: empty table, identical and opposite vectors, sweeps.
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, 0, 1, 10), 1,
                      cnfm_pkg::STATUS_ENROL, 0, -32768)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, 32767, 1, 11), 1,
                      cnfm_pkg::STATUS_ENROL, 1, -32768)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, 32767, 1, 12), 1,
                      cnfm_pkg::STATUS_MATCH, 1, 32767)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, -32768, 1, 13), 1,
                      cnfm_pkg::STATUS_ENROL, 2, -32768)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_EXPIRE, -1, 1, 14), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, 100, 0, 15), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_EXPIRE, 0, 0, 0), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, -100, 0, 16), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, 5, 1, 17), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, -32768, 0, 18), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, 32767, 1, 19), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, 'h5555, 1, 20), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, 'hAAAA, 1, 21), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, 'h5555, 1, 22), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_EXPIRE, 'h7FFF, 0, 32'hFFFF_FFFF), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, 32767, 1, 32'hFFFF_FFFF), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      dir = {dir, row(mk_req(cnfm_pkg::ACTION_ELEMENT, -32768, 1, 32'hFFFF_FFFF), 0,
                      cnfm_pkg::STATUS_MATCH, 0, 0)};
      foreach (dir[i]) send_request(dir[i].r, dir[i].typed, dir[i].e);
      drain_results();

      // Register settings per phase: match, enrol, expiry age.
      phase_cfg = '{'{19661, 16384, 1800}, '{32767, 32767, 24'hFFFFFF},
                    '{-32768, -32768, 0}, '{30000, 10000, 40}, '{0, -32768, 200}};
      tnow = 100;
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(cnfm_pkg::CSR_MATCH,
                   {$urandom} & 32'hFFFF_0000 | (phase_cfg[ph][0] & 32'hFFFF));
         csr_write(cnfm_pkg::CSR_ENROL,
                   {$urandom} & 32'hFFFF_0000 | (phase_cfg[ph][1] & 32'hFFFF));
         csr_write(cnfm_pkg::CSR_EXPIRE, {$urandom} & 32'hFF00_0000 | phase_cfg[ph][2]);
         for (int a = 0; a < 8; a++)
            for (int b = 0; b < 8; b++) proto[a][b] = shortint'($urandom);
         quota = (ph == 1) ? 250 : 375;
         n_items = 0;
         burst = $urandom_range(1, 40);
         while (n_items < quota) begin
            rnd = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0) tnow = $urandom;
            else tnow += $urandom_range(0, 30);
            if (rnd < 8) begin
               // Expiry sweep with random ignored fields.
               send_request(mk_req(cnfm_pkg::ACTION_EXPIRE, $urandom,
                                   1'($urandom_range(0, 1)),
                                   tnow - $urandom_range(0, 3)), 0, none);
               n_items++;
            end else begin
               // A query vector built around one prototype.
               len = ($urandom_range(0, 59) == 0) ? $urandom_range(120, 135)
                                                  : $urandom_range(1, 6);
               p = $urandom_range(0, 7);
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(0, 9) == 0) elem = $urandom;
                  else elem = int'(proto[p][i % 8]) + int'($urandom_range(0, 6)) - 3;
                  if (elem > 32767) elem = 32767;
                  if (elem < -32768) elem = -32768;
                  send_request(mk_req(cnfm_pkg::ACTION_ELEMENT, elem, i == len - 1, tnow),
                               0, none);
                  n_items++;
                  if (--burst == 0) begin
                     idle_sender($urandom_range(1, 150));
                     burst = $urandom_range(1, 40);
                  end
               end
            end
            // Hold off until the table has answered everything.
            if ($urandom_range(0, 99) == 0) begin
               idle_sender(0);
               while (pending_rsp.size() != 0) @(posedge clock);
            end
         end
         drain_results();
      end

      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
